>>> rtl/olad_pkg.sv
// Package for the ordered list block: field widths, operation and status codes,
// sequencer states. No dependencies.
package olad_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 5;
    localparam int DEF_CAPACITY  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_ENTRY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_READ,
        S_REPLY
    } state_t;

endpackage

>>> rtl/olad_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module olad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ordered_list_append_delete.sv
// Top level of the ordered list block: sequencer, count and output register.
// Depends on olad_pkg and olad_ram.
//
// Bounded ordered list of signed 32-bit values, held head first in one RAM of
// CAPACITY words. Each input transaction is worked on alone; in_stall is high
// from acceptance until the sequencer is back in idle. An append, or the
// unused operation code, is done on acceptance and its result then sits in
// the output register. A delete walks the list one entry a cycle through
// the single RAM read port: up to and including the match (all count
// entries when there is none), then through each later entry to close the
// gap, the compare stage and the shift stage sharing that read port; the
// reply state follows. A read-out emits one entry a cycle while the output
// side does not stall. An empty list answers a delete or read-out with an
// empty status and no walk. The RAM is not cleared at reset: only data from
// slots below the count is ever used. Results leave through a single output
// register; the sequencer waits on it in its read-out and reply states
// whenever the far side stalls a held result.
module ordered_list_append_delete #(
    parameter int CAPACITY = olad_pkg::DEF_CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [olad_pkg::OP_W-1:0]             operation,
    input  logic signed [olad_pkg::DATA_W-1:0]    value,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [olad_pkg::STATUS_W-1:0]         status,
    output logic signed [olad_pkg::DATA_W-1:0]    entry,
    output logic [olad_pkg::ENTRY_COUNT_W-1:0]    entry_count,
    output logic                                  last
);

    import olad_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // sequencer state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             reply_reg, reply_next;
    logic [DATA_W-1:0]   value_reg, value_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   entry_reg, entry_next;
    logic [CNT_W-1:0]    count_out_reg, count_out_next;
    logic                last_reg, last_next;

    // RAM port signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;

    logic                out_free;
    logic                load_out;
    logic                at_tail;
    logic                is_full;
    logic                is_empty;
    logic [CNT_W-1:0]    ptr_inc;

    olad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_next),   // data for ptr_reg arrives with it
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign ptr_inc  = CNT_W'(ptr_reg) + CNT_W'(1);
    assign at_tail  = (ptr_inc == count_reg);
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        count_next     = count_reg;
        reply_next     = reply_reg;
        value_next     = value_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = value_reg;
        load_out       = 1'b0;
        status_next    = status_reg;
        entry_next     = entry_reg;
        count_out_next = count_out_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                ptr_next = '0;
                if (in_valid)
                begin
                    value_next = value;
                    state_next = S_REPLY;
                    reply_next = ST_DONE;
                    case (operation)
                        OP_APPEND:
                        begin
                            if (is_full)
                            begin
                                reply_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = value;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (is_empty)
                                reply_next = ST_EMPTY;
                            else
                                state_next = S_SEARCH;
                        end
                        OP_READ:
                        begin
                            if (is_empty)
                                reply_next = ST_EMPTY;
                            else
                                state_next = S_READ;
                        end
                        default:
                        begin
                            reply_next = ST_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (ram_rdata == value_reg)
                begin
                    if (at_tail)
                    begin
                        // match on the tail: nothing to close up
                        count_next = count_reg - CNT_W'(1);
                        reply_next = ST_DONE;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + ADDR_W'(1);
                        state_next = S_SHIFT;
                    end
                end
                else if (at_tail)
                begin
                    reply_next = ST_NOTFOUND;
                    state_next = S_REPLY;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end

            S_SHIFT:
            begin
                // move slot ptr down by one
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (at_tail)
                begin
                    count_next = count_reg - CNT_W'(1);
                    reply_next = ST_DONE;
                    state_next = S_REPLY;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    status_next    = ST_ENTRY;
                    entry_next     = ram_rdata;
                    count_out_next = count_reg;
                    last_next      = at_tail;
                    if (at_tail)
                        state_next = S_IDLE;
                    else
                        ptr_next = ptr_reg + ADDR_W'(1);
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    status_next    = reply_reg;
                    entry_next     = '0;
                    count_out_next = count_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            reply_reg     <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        status_reg    <= status_next;
        entry_reg     <= entry_next;
        count_out_reg <= count_out_next;
        last_reg      <= last_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry       = entry_reg;
    assign entry_count = ENTRY_COUNT_W'(count_out_reg);
    assign last        = last_reg;

    // count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    // walking pointer stays on held slots
    a_ptr_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH || state_reg == S_SHIFT || state_reg == S_READ)
        |-> ptr_inc <= count_reg)
        else $error("pointer past tail");

    // a read-out leaves the count alone
    a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> count_reg == $past(count_reg))
        else $error("count changed during read-out");

    // every result other than a read-out entry closes the transaction
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_ENTRY) |-> (last_reg && entry_reg == '0))
        else $error("non-entry result without last");

    // no new transaction while the gap is being closed
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> in_stall)
        else $error("input taken during shift");

endmodule
